[design/alloc_range_table_unit_macros.svh]
// ----------------------------------------------------------------------------
// Allocation range table: assertion macros
// Shared check forms used by the assertions at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ALLOC_RANGE_TABLE_UNIT_MACROS_SVH
`define ALLOC_RANGE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define ARTU_CHECK(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define ARTU_CHECK_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[design/artu_pkg.sv]
// ----------------------------------------------------------------------------
// Allocation range table package
// Table sizing, field widths, command/status codes and shared structs.
// ----------------------------------------------------------------------------
package artu_pkg;

   // Table sizing
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int CMD_W         = 2;
   localparam int ADDR_W        = 64;
   localparam int LEN_W         = 64;
   localparam int STATUS_W      = 2;
   localparam int KIND_W        = 2;
   localparam int ENTRY_COUNT_W = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OFF  = 2'd3;

   // Match kinds
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INNER = 2'd2;

   // Sequencer to entry memory
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [ADDR_W-1:0] wr_base;
      logic [LEN_W-1:0]  wr_len;
      logic [IDX_W-1:0]  rd_addr;
   } ram_req_type;

   // Compare unit to sequencer
   typedef struct packed {
      logic exact;
      logic inner;
   } match_type;

endpackage

[design/artu_if.sv]
// ----------------------------------------------------------------------------
// Allocation range table channel interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface artu_req_if;
   logic                          valid;
   logic                          ready;
   logic [artu_pkg::CMD_W-1:0]    cmd;
   logic [artu_pkg::ADDR_W-1:0]   addr;
   logic [artu_pkg::LEN_W-1:0]    length;

   modport source (output valid, cmd, addr, length, input ready);
   modport sink   (input valid, cmd, addr, length, output ready);
endinterface

interface artu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [artu_pkg::STATUS_W-1:0]        status;
   logic [artu_pkg::KIND_W-1:0]          match_kind;
   logic [artu_pkg::ADDR_W-1:0]          handle;
   logic [artu_pkg::ENTRY_COUNT_W-1:0]   entry_count;

   modport source (output valid, status, match_kind, handle, entry_count, input ready);
   modport sink   (input valid, status, match_kind, handle, entry_count, output ready);
endinterface

[design/artu_entry_ram.sv]
// ----------------------------------------------------------------------------
// Allocation range table entry memory
// Base and size arrays, one write port and one registered read port.
// ----------------------------------------------------------------------------
module artu_entry_ram (
   input  logic                          clock,
   input  artu_pkg::ram_req_type         ram_req,
   output logic [artu_pkg::ADDR_W-1:0]   rd_base,
   output logic [artu_pkg::LEN_W-1:0]    rd_len
);

   logic [artu_pkg::ADDR_W-1:0] base_mem [artu_pkg::TABLE_DEPTH];
   logic [artu_pkg::LEN_W-1:0]  len_mem  [artu_pkg::TABLE_DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         base_mem[ram_req.wr_addr] <= ram_req.wr_base;
         len_mem[ram_req.wr_addr]  <= ram_req.wr_len;
      end
   end

   // Registered read port, read-before-write
   always_ff @(posedge clock) begin
      rd_base <= base_mem[ram_req.rd_addr];
      rd_len  <= len_mem[ram_req.rd_addr];
   end

endmodule

[design/artu_match_unit.sv]
// ----------------------------------------------------------------------------
// Allocation range table compare unit
// Exact base and interior range checks of one entry against the address.
// ----------------------------------------------------------------------------
module artu_match_unit (
   input  logic [artu_pkg::ADDR_W-1:0] addr,
   input  logic [artu_pkg::ADDR_W-1:0] base,
   input  logic [artu_pkg::LEN_W-1:0]  len,
   output artu_pkg::match_type         match
);

   logic [artu_pkg::ADDR_W-1:0] offset;

   // addr > base keeps the offset from wrapping; comparing it with len forms no sum
   assign offset      = addr - base;
   assign match.exact = (addr == base);
   assign match.inner = (addr > base) && (offset < len);

endmodule

[design/artu_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocation range table sequencer
// Takes one command, runs the exact scan and, for lookups, the interior scan
// through the shared compare unit, does the swap-with-last on remove and
// stages the result.
module artu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enabled,
   artu_req_if.sink                      req,
   artu_rsp_if.source                    rsp,
   output artu_pkg::ram_req_type         ram_req,
   input  logic [artu_pkg::ADDR_W-1:0]   rd_base,
   input  logic [artu_pkg::LEN_W-1:0]    rd_len,
   input  artu_pkg::match_type           match,
   output logic [artu_pkg::ADDR_W-1:0]   scan_addr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXACT,
      S_INNER,
      S_RM_LAST,
      S_RM_WRITE,
      S_FINISH
   } state_type;

   state_type                              state_ff, state_in;
   logic [artu_pkg::CMD_W-1:0]             cmd_ff, cmd_in;
   logic [artu_pkg::ADDR_W-1:0]            addr_ff, addr_in;
   logic [artu_pkg::CNT_W-1:0]             count_ff, count_in;
   logic [artu_pkg::CNT_W-1:0]             scan_ff, scan_in;
   logic                                   pend_ff, pend_in;
   logic [artu_pkg::IDX_W-1:0]             pend_idx_ff, pend_idx_in;
   logic [artu_pkg::IDX_W-1:0]             slot_ff, slot_in;
   logic [artu_pkg::STATUS_W-1:0]          res_status_ff, res_status_in;
   logic [artu_pkg::KIND_W-1:0]            res_kind_ff, res_kind_in;
   logic [artu_pkg::ADDR_W-1:0]            res_handle_ff, res_handle_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [artu_pkg::STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [artu_pkg::KIND_W-1:0]            rsp_kind_ff, rsp_kind_in;
   logic [artu_pkg::ADDR_W-1:0]            rsp_handle_ff, rsp_handle_in;
   logic [artu_pkg::ENTRY_COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [artu_pkg::CNT_W-1:0]             last_cnt;
   logic                                   hit;

   assign last_cnt  = count_ff - artu_pkg::CNT_W'(1);
   assign scan_addr = addr_ff;
   assign hit       = pend_ff && ((state_ff == S_EXACT) ? match.exact : match.inner);

   // Ports; no command transfer while in reset
   assign req.ready       = (state_ff == S_IDLE) && !reset;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.match_kind  = rsp_kind_ff;
   assign rsp.handle      = rsp_handle_ff;
   assign rsp.entry_count = rsp_count_ff;

   // Next state and memory requests
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_kind_in   = res_kind_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = count_ff[artu_pkg::IDX_W-1:0];
      ram_req.wr_base = req.addr;
      ram_req.wr_len  = req.length;
      ram_req.rd_addr = scan_ff[artu_pkg::IDX_W-1:0];

      // Result taken downstream
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in        = req.cmd;
               addr_in       = req.addr;
               scan_in       = '0;
               pend_in       = 1'b0;
               res_status_in = artu_pkg::STATUS_DONE;
               res_kind_in   = artu_pkg::KIND_NONE;
               res_handle_in = '0;
               if (!enabled) begin
                  res_status_in = artu_pkg::STATUS_OFF;
                  state_in      = S_FINISH;
               end else begin
                  unique case (req.cmd)
                     artu_pkg::CMD_INSERT: begin
                        if (count_ff < artu_pkg::CNT_W'(artu_pkg::TABLE_DEPTH)) begin
                           ram_req.wr_en = 1'b1;
                           count_in      = count_ff + artu_pkg::CNT_W'(1);
                        end else begin
                           res_status_in = artu_pkg::STATUS_FULL;
                        end
                        state_in = S_FINISH;
                     end
                     artu_pkg::CMD_REMOVE, artu_pkg::CMD_LOOKUP: begin
                        state_in = S_EXACT;
                     end
                     default: begin
                        // unused command code: no effect
                        state_in = S_FINISH;
                     end
                  endcase
               end
            end
         end

         // One entry read per cycle, compared in the cycle after its read
         S_EXACT, S_INNER: begin
            if (hit) begin
               slot_in = pend_idx_ff;
               pend_in = 1'b0;
               if (state_ff == S_EXACT && cmd_ff == artu_pkg::CMD_REMOVE) begin
                  state_in = S_RM_LAST;
               end else begin
                  res_kind_in   = (state_ff == S_EXACT) ? artu_pkg::KIND_EXACT
                                                        : artu_pkg::KIND_INNER;
                  res_handle_in = addr_ff;
                  state_in      = S_FINISH;
               end
            end else if (scan_ff < count_ff) begin
               scan_in     = scan_ff + artu_pkg::CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[artu_pkg::IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (state_ff == S_EXACT && cmd_ff == artu_pkg::CMD_LOOKUP) begin
                  scan_in  = '0;
                  state_in = S_INNER;
               end else begin
                  res_status_in = artu_pkg::STATUS_MISS;
                  state_in      = S_FINISH;
               end
            end
         end

         // Fetch the last entry
         S_RM_LAST: begin
            ram_req.rd_addr = last_cnt[artu_pkg::IDX_W-1:0];
            state_in        = S_RM_WRITE;
         end

         // Move it into the freed slot
         S_RM_WRITE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_ff;
            ram_req.wr_base = rd_base;
            ram_req.wr_len  = rd_len;
            count_in        = last_cnt;
            state_in        = S_FINISH;
         end

         // Hand result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_handle_in = res_handle_ff;
               rsp_count_in  = artu_pkg::ENTRY_COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_kind_ff   <= res_kind_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

[design/alloc_range_table_unit.sv]
// Remove/lookup: one memory read per entry per scan pass; a lookup miss runs
// both the exact and the interior pass. Not ready while a command runs.
// One command at a time: the next command transfers once the result is staged.
// Reset (synchronous, active high) empties the table and disables the block.
// ----------------------------------------------------------------------------
// Allocation range table unit
// Table of base/size allocations with insert, remove and address lookup.
// ----------------------------------------------------------------------------
`include "alloc_range_table_unit_macros.svh"

module alloc_range_table_unit (
   input  logic         clock,
   input  logic         reset,
   artu_req_if.sink     req_port,
   artu_rsp_if.source   rsp_port,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic                          enabled_ff, enabled_in;
   artu_pkg::ram_req_type         ram_req;
   logic [artu_pkg::ADDR_W-1:0]   rd_base;
   logic [artu_pkg::LEN_W-1:0]    rd_len;
   logic [artu_pkg::ADDR_W-1:0]   scan_addr;
   artu_pkg::match_type           match;

   // Enable register
   assign enabled_in = csr_wr_en ? csr_wr_data : enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   // Sequencer
   artu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .enabled   (enabled_ff),
      .req       (req_port),
      .rsp       (rsp_port),
      .ram_req   (ram_req),
      .rd_base   (rd_base),
      .rd_len    (rd_len),
      .match     (match),
      .scan_addr (scan_addr)
   );

   // Entry memory
   artu_entry_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_base (rd_base),
      .rd_len  (rd_len)
   );

   // Shared compare unit
   artu_match_unit u_match (
      .addr  (scan_addr),
      .base  (rd_base),
      .len   (rd_len),
      .match (match)
   );

   // Checks
   `ARTU_CHECK_NEXT(a_busy_after_transfer, req_port.valid && req_port.ready, !req_port.ready, "ready after command transfer")
   `ARTU_CHECK(a_count_bound, rsp_port.valid, rsp_port.entry_count <= artu_pkg::ENTRY_COUNT_W'(artu_pkg::TABLE_DEPTH), "entry count beyond depth")
   `ARTU_CHECK(a_full_count, rsp_port.valid && rsp_port.status == artu_pkg::STATUS_FULL, rsp_port.entry_count == artu_pkg::ENTRY_COUNT_W'(artu_pkg::TABLE_DEPTH), "full reported below depth")
   `ARTU_CHECK(a_hit_done, rsp_port.valid && rsp_port.match_kind != artu_pkg::KIND_NONE, rsp_port.status == artu_pkg::STATUS_DONE, "match with non-done status")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocation range table unit testbench
// Drives insert, remove and lookup commands through the request channel and
// checks every response against a cycle-free model of the table kept here.
// Directed cases cover the disabled state, zero-size and wrap-limit ranges,
// duplicates and the unused command code. Random phases then fill the table
// to its limit, drain it and look up exact, interior and boundary addresses,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [artu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int               CYCLE_LIMIT = 1_000_000;
   localparam int               MAX_REPORTS = 10;

   typedef struct packed {
      logic [artu_pkg::STATUS_W-1:0]      status;
      logic [artu_pkg::KIND_W-1:0]        kind;
      logic [artu_pkg::ADDR_W-1:0]        handle;
      logic [artu_pkg::ENTRY_COUNT_W-1:0] count;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   artu_req_if req_ch ();
   artu_rsp_if rsp_ch ();

   alloc_range_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_ch),
      .rsp_port    (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Table model: bases, sizes, count and the enable register
   logic [artu_pkg::ADDR_W-1:0] tbl_base [artu_pkg::TABLE_DEPTH];
   logic [artu_pkg::LEN_W-1:0]  tbl_len  [artu_pkg::TABLE_DEPTH];
   int                tbl_count;
   logic              tbl_enabled;

   lookup_result_type pending_results [$];

   int  mismatches;
   int  unexpected;
   int  n_transfers;
   int  n_full;
   int  n_exact;
   int  n_inner;
   int  n_miss;
   int  n_off;
   longint cycle_count;
   bit  send_gaps_on;
   bit  rsp_stalls_on;

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // First slot, in index order, whose base equals a; -1 if none
   function automatic int exact_slot(logic [artu_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_base[i] == a) return i;
      return -1;
   endfunction

   // Interior hit: base < a < base + size, without wrap of the sum
   function automatic bit inside_any(logic [artu_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < tbl_count; i++)
         if (a > tbl_base[i] && (a - tbl_base[i]) < tbl_len[i]) return 1'b1;
      return 1'b0;
   endfunction

   // Apply one command to the table model and return the response it gives
   function automatic lookup_result_type table_apply(logic [artu_pkg::CMD_W-1:0] cmd,
                                                     logic [artu_pkg::ADDR_W-1:0] a,
                                                     logic [artu_pkg::LEN_W-1:0] len);
      lookup_result_type r;
      int slot;
      r = '0;
      r.status = artu_pkg::STATUS_DONE;
      r.kind   = artu_pkg::KIND_NONE;
      if (!tbl_enabled) begin
         r.status = artu_pkg::STATUS_OFF;
      end else if (cmd == artu_pkg::CMD_INSERT) begin
         if (tbl_count < artu_pkg::TABLE_DEPTH) begin
            tbl_base[tbl_count] = a;
            tbl_len[tbl_count]  = len;
            tbl_count++;
         end else begin
            r.status = artu_pkg::STATUS_FULL;
         end
      end else if (cmd == artu_pkg::CMD_REMOVE) begin
         slot = exact_slot(a);
         if (slot >= 0) begin
            tbl_base[slot] = tbl_base[tbl_count-1];
            tbl_len[slot]  = tbl_len[tbl_count-1];
            tbl_count--;
         end else begin
            r.status = artu_pkg::STATUS_MISS;
         end
      end else if (cmd == artu_pkg::CMD_LOOKUP) begin
         if (exact_slot(a) >= 0) begin
            r.kind   = artu_pkg::KIND_EXACT;
            r.handle = a;
         end else if (inside_any(a)) begin
            r.kind   = artu_pkg::KIND_INNER;
            r.handle = a;
         end else begin
            r.status = artu_pkg::STATUS_MISS;
         end
      end
      r.count = tbl_count[artu_pkg::ENTRY_COUNT_W-1:0];
      return r;
   endfunction

   // Send one command: random gap with valid low, then hold until transfer
   task automatic send_cmd(logic [artu_pkg::CMD_W-1:0] cmd, logic [artu_pkg::ADDR_W-1:0] a,
                           logic [artu_pkg::LEN_W-1:0] len);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cmd    <= cmd;
      req_ch.addr   <= a;
      req_ch.length <= len;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      pending_results.push_back(table_apply(cmd, a, len));
      n_transfers++;
   endtask

   // Drop valid and wait until every outstanding response has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Enable register write; only called with nothing in flight
   task automatic write_enabled(logic v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tbl_enabled = v;
   endtask

   // Interior address of entry idx; base + 1 when its size is below 2, else base when base is all ones
   function automatic logic [artu_pkg::ADDR_W-1:0] pick_inner(int idx);
      logic [artu_pkg::ADDR_W-1:0] b;
      logic [artu_pkg::LEN_W-1:0]  span;
      b = tbl_base[idx];
      if (tbl_len[idx] < 2) return b + 1;
      span = tbl_len[idx] - 1;
      if (span > ~b) span = ~b;
      if (span == 0) return b;
      return b + 1 + (rand64() % span);
   endfunction

   function automatic logic [artu_pkg::LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 60) return artu_pkg::LEN_W'($urandom_range(1, 4096));
      if (r < 85) return rand64();
      return '1;
   endfunction

   // Bases either reused from the table, anywhere, or packed in a narrow window so ranges overlap
   function automatic logic [artu_pkg::ADDR_W-1:0] pick_base();
      if ($urandom_range(0, 3) == 0 && tbl_count > 0)
         return tbl_base[$urandom_range(0, tbl_count-1)];
      if ($urandom_range(0, 1) == 0) return rand64();
      return 64'h0000_7f00_0000_0000 + $urandom_range(0, 65535);
   endfunction

   // Blind remove or lookup
   function automatic logic [artu_pkg::CMD_W-1:0] pick_blind_cmd();
      return $urandom_range(0, 1) ? artu_pkg::CMD_LOOKUP : artu_pkg::CMD_REMOVE;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the block is disabled: every command reports it
   task automatic test_disabled();
      send_cmd(artu_pkg::CMD_INSERT, 64'h1000, 64'h100);
      send_cmd(artu_pkg::CMD_REMOVE, 64'h1000, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1000, '0);
      send_cmd(CMD_UNUSED, rand64(), rand64());
      wait_drained();
   endtask

   // Field extremes, zero size, no-wrap ranges, duplicates, unused code
   task automatic test_directed();
      write_enabled(1'b1);
      send_cmd(artu_pkg::CMD_INSERT, '0, '0);
      send_cmd(artu_pkg::CMD_INSERT, '1, '1);
      send_cmd(artu_pkg::CMD_INSERT, 64'h1000, 64'h100);
      send_cmd(artu_pkg::CMD_INSERT, 64'hffff_ffff_ffff_ff00, '1);
      send_cmd(artu_pkg::CMD_LOOKUP, '0, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1000, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1080, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h10ff, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1100, '1);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'hffff_ffff_ffff_fffe, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, '1, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h10, '0);
      send_cmd(artu_pkg::CMD_INSERT, 64'h1000, 64'h10);
      send_cmd(artu_pkg::CMD_REMOVE, 64'h1000, '1);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1080, '0);
      send_cmd(artu_pkg::CMD_REMOVE, 64'h5555, '0);
      send_cmd(CMD_UNUSED, rand64(), rand64());
      send_cmd(artu_pkg::CMD_REMOVE, '1, '0);
      send_cmd(artu_pkg::CMD_REMOVE, '0, '0);
      send_cmd(artu_pkg::CMD_REMOVE, 64'hffff_ffff_ffff_ff00, '0);
      send_cmd(artu_pkg::CMD_REMOVE, 64'h1000, '0);
      send_cmd(artu_pkg::CMD_REMOVE, 64'h1000, '0);
      send_cmd(artu_pkg::CMD_LOOKUP, 64'h1000, '0);
      wait_drained();
   endtask

   // One random phase; insert_pct steers the table towards full or empty
   task automatic test_random_phase(int n_items, int insert_pct, logic en);
      int r;
      int idx;
      logic [artu_pkg::ADDR_W-1:0] a;
      write_enabled(en);
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         idx = (tbl_count > 0) ? $urandom_range(0, tbl_count-1) : 0;
         if (r < insert_pct) begin
            send_cmd(artu_pkg::CMD_INSERT, pick_base(), pick_len());
         end else if (r < insert_pct + (100 - insert_pct) * 35 / 100) begin
            a = ($urandom_range(0, 4) != 0 && tbl_count > 0) ? tbl_base[idx] : rand64();
            send_cmd(artu_pkg::CMD_REMOVE, a, rand64());
         end else if (r < 92) begin
            r = $urandom_range(0, 9);
            if (tbl_count == 0 || r >= 8)  a = rand64();
            else if (r < 3)                a = tbl_base[idx];
            else if (r < 7)                a = pick_inner(idx);
            else                           a = tbl_base[idx] + tbl_len[idx];
            send_cmd(artu_pkg::CMD_LOOKUP, a, rand64());
         end else begin
            // Noise: unused code or a blind remove/lookup
            send_cmd(logic'($urandom_range(0, 1)) ? CMD_UNUSED : pick_blind_cmd(),
                     rand64(), rand64());
         end
         // Occasionally hold off until the pipeline is empty
         if ($urandom_range(0, 49) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------
   lookup_result_type got;
   lookup_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = rsp_ch.status;
         got.kind   = rsp_ch.match_kind;
         got.handle = rsp_ch.handle;
         got.count  = rsp_ch.entry_count;
         if (pending_results.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= MAX_REPORTS)
               $display("[%0t] response with none outstanding: status %0d count %0d",
                        $realtime, got.status, got.count);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.kind !== want.kind ||
                got.handle !== want.handle || got.count !== want.count) begin
               mismatches++;
               if (mismatches + unexpected <= MAX_REPORTS)
                  $display({"[%0t] mismatch: status %0d/%0d kind %0d/%0d ",
                            "handle %h/%h count %0d/%0d (expected/actual)"},
                           $realtime, want.status, got.status, want.kind, got.kind,
                           want.handle, got.handle, want.count, got.count);
            end
            case (got.status)
               artu_pkg::STATUS_FULL: n_full++;
               artu_pkg::STATUS_MISS: n_miss++;
               artu_pkg::STATUS_OFF:  n_off++;
               default:     ;
            endcase
            if (got.kind == artu_pkg::KIND_EXACT) n_exact++;
            if (got.kind == artu_pkg::KIND_INNER) n_inner++;
         end
      end
   end

   // Response ready: random stall before each transfer
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         n = rsp_stalls_on ? $urandom_range(0, 15) : 0;
         @(negedge clock);
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid  = 1'b0;
      req_ch.cmd    = artu_pkg::CMD_INSERT;
      req_ch.addr   = '0;
      req_ch.length = '0;
      tbl_count     = 0;
      tbl_enabled   = 1'b0;
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_disabled();
      test_directed();
      test_random_phase(130, 75, 1'b1);
      send_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_phase(120, 45, 1'b1);
      send_gaps_on = 1'b1;
      test_random_phase(40, 50, 1'b0);
      rsp_stalls_on = 1'b1;
      test_random_phase(130, 15, 1'b1);
      test_random_phase(180, 50, 1'b1);
      write_enabled(1'b0);

      wait_drained();
      repeat (20) @(negedge clock);
      $display("Ran %0d commands: %0d exact hits, %0d interior hits, %0d misses,",
               n_transfers, n_exact, n_inner, n_miss);
      $display("%0d inserts refused when full, %0d commands while disabled",
               n_full, n_off);
      if (mismatches == 0 && unexpected == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[alloc_range_table_unit.f]
+incdir+design
design/artu_pkg.sv
design/artu_if.sv
design/artu_entry_ram.sv
design/artu_match_unit.sv
design/artu_ctrl.sv
design/alloc_range_table_unit.sv
bench/tb_top.sv
